@@ hdl/trmaf_pkg.sv @@
// Shared constants, payload types and lane helpers for the trimmed moving average filter.
package trmaf_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int SAMPLE_MAX     = 4095;
   localparam int CHAN_COUNT     = 5;
   localparam int WINDOW_LEN_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEP_W     = $clog2(SAMPLE_W);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type [CHAN_COUNT-1:0] lanes_type;

   typedef struct packed {
      sample_type sample_gas_one;
      sample_type sample_gas_two;
      sample_type sample_therm_one;
      sample_type sample_therm_two;
      sample_type sample_supply;
   } req_payload_type;

   typedef struct packed {
      sample_type filtered_gas_one;
      sample_type filtered_gas_two;
      sample_type filtered_therm_one;
      sample_type filtered_therm_two;
      sample_type filtered_supply;
   } rsp_payload_type;

   function automatic lanes_type to_lanes(input req_payload_type req);
      lanes_type lanes;
      lanes[0] = req.sample_gas_one;
      lanes[1] = req.sample_gas_two;
      lanes[2] = req.sample_therm_one;
      lanes[3] = req.sample_therm_two;
      lanes[4] = req.sample_supply;
      return lanes;
   endfunction

   function automatic rsp_payload_type from_lanes(input lanes_type lanes);
      rsp_payload_type rsp;
      rsp.filtered_gas_one   = lanes[0];
      rsp.filtered_gas_two   = lanes[1];
      rsp.filtered_therm_one = lanes[2];
      rsp.filtered_therm_two = lanes[3];
      rsp.filtered_supply    = lanes[4];
      return rsp;
   endfunction

endpackage

@@ hdl/trmaf_ifs.sv @@
// Valid/ready channel interfaces for sample requests and filtered responses.
interface trmaf_req_if import trmaf_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface trmaf_rsp_if import trmaf_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/trimmed_moving_average_filter.sv @@
// Top level of the five-channel trimmed moving average filter.
// A request passes the intake queue, the engine's idle accept, the window scan through the single
// RAM read port (one read per window slot), then net, multiply and response load steps. The engine
// takes a new request only once the previous result is loaded into the response register.
// Reset (synchronous, active high) clears control state; a fill count makes unwritten window
// slots read as zero, so no clearing pass is needed and requests are taken right after reset.
module trimmed_moving_average_filter import trmaf_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   trmaf_req_if.sink   req_chan,
   trmaf_rsp_if.source rsp_chan
);

   trmaf_req_if job_chan ();

   trmaf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .job_chan (job_chan.source)
   );

   trmaf_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_chan (job_chan.sink),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ hdl/trmaf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module trmaf_ram import trmaf_pkg::*; #(
   parameter int WIDTH = SAMPLE_W * CHAN_COUNT,
   parameter int DEPTH = WINDOW_LEN_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/trmaf_front.sv @@
// Front end: request intake queue that decouples the input channel from the filter engine.
module trmaf_front import trmaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   trmaf_req_if.sink   req_chan,
   trmaf_req_if.source job_chan
);

   req_payload_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign req_chan.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign job_chan.valid = (count_ff != '0);
   assign job_chan.data  = entry_ff[rd_ptr_ff];

   assign push = req_chan.valid && req_chan.ready;
   assign pop  = job_chan.valid && job_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_chan.data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("queue count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");

endmodule

@@ hdl/trmaf_back.sv @@
// Back end: window write, sum/max/min scan over the window RAM, and reciprocal-multiply divide.
module trmaf_back import trmaf_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   trmaf_req_if.sink   job_chan,
   trmaf_rsp_if.source rsp_chan
);

   localparam int AW      = $clog2(WINDOW_LEN);
   localparam int CW      = $clog2(WINDOW_LEN + 1);
   localparam int SW      = $clog2(SAMPLE_MAX * WINDOW_LEN + 1);
   localparam int DIVISOR = WINDOW_LEN - 2;
   localparam int LW      = $clog2(DIVISOR);
   localparam int SHIFT   = SW + LW;
   localparam int MW      = SW + 1;
   localparam int PW      = SW + MW;
   localparam int QW      = SAMPLE_W;
   localparam int RAM_W   = SAMPLE_W * CHAN_COUNT;

   // ceil(2^SHIFT / DIVISOR) gives an exact quotient for every net below 2^SW
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [SW-1:0]         sum_ff [CHAN_COUNT];
   logic [SW-1:0]         sum_in [CHAN_COUNT];
   lanes_type             hi_ff, hi_in;
   lanes_type             lo_ff, lo_in;
   logic [SW-1:0]         net_ff [CHAN_COUNT];
   logic [SW-1:0]         net_in [CHAN_COUNT];
   lanes_type             quo_ff, quo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [SW-1:0]         net [CHAN_COUNT];
   logic [PW-1:0]         prod [CHAN_COUNT];
   lanes_type             scan_val;
   lanes_type             rd_lanes;
   logic [RAM_W-1:0]      rd_data;
   logic                  ram_rd_en;
   logic                  job_take;
   logic                  rsp_load;

   assign job_chan.ready = (state_ff == ST_IDLE);
   assign job_take       = job_chan.valid && job_chan.ready;
   assign ram_rd_en      = (state_ff == ST_SCAN) && (cnt_ff != CW'(WINDOW_LEN));
   assign rsp_load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rd_lanes       = lanes_type'(rd_data);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   trmaf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW_LEN)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (job_take),
      .wr_addr (slot_ff),
      .wr_data (RAM_W'(to_lanes(job_chan.data))),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // entries past the fill count were never written and read as zero
   always_comb begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
         scan_val[c] = (CW'(rd_idx_ff) < fill_ff) ? rd_lanes[c] : '0;
         net[c]      = sum_ff[c] - SW'(hi_ff[c]) - SW'(lo_ff[c]);
         prod[c]     = PW'(net_ff[c]) * PW'(RECIP);
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      net_in       = net_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_chan.valid) begin
               slot_in = (slot_ff == AW'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
               if (fill_ff != CW'(WINDOW_LEN)) begin
                  fill_in = fill_ff + 1'b1;
               end
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               for (int c = 0; c < CHAN_COUNT; c++) begin
                  if (rd_idx_ff == '0) begin
                     sum_in[c] = SW'(scan_val[c]);
                     hi_in[c]  = scan_val[c];
                     lo_in[c]  = scan_val[c];
                  end else begin
                     sum_in[c] = sum_ff[c] + SW'(scan_val[c]);
                     if (scan_val[c] > hi_ff[c]) begin
                        hi_in[c] = scan_val[c];
                     end
                     if (scan_val[c] < lo_ff[c]) begin
                        lo_in[c] = scan_val[c];
                     end
                  end
               end
            end
            rd_idx_in = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(WINDOW_LEN)) begin
               state_in = ST_PREP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PREP: begin
            net_in   = net;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // quotient fits 12 bits
            for (int c = 0; c < CHAN_COUNT; c++) begin
               quo_in[c] = prod[c][SHIFT +: QW];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = from_lanes(quo_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      sum_ff      <= sum_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      net_ff      <= net_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      job_take |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("request taken without starting a window scan");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= CW'(WINDOW_LEN)) && (slot_ff <= AW'(WINDOW_LEN - 1)))
      else $error("fill count or write slot out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not loaded into response register");

endmodule
